### rtl/core/ema_rms_peak_level_meter_top_assert.svh
// assertion macros of the level meter checker
`ifndef EMA_RMS_PEAK_LEVEL_METER_TOP_ASSERT_SVH
`define EMA_RMS_PEAK_LEVEL_METER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ERPM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("level meter check failed");

// next-cycle implication, disabled in reset
`define ERPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("level meter check failed");

`endif

### rtl/core/erpm_pkg.sv
// shared constants and types of the level meter
`default_nettype none

package erpm_pkg;

   // default widths
   localparam int SampleBitsDefault = 24;
   localparam int WeightBitsDefault = 32;

   // register port width and reset value of the smoothing weight
   localparam int CsrBits = 32;
   localparam logic [CsrBits-1:0] WeightResetValue = 32'd324638;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SCALE,
      ST_ROOT,
      ST_EMIT
   } erpm_state_type;

endpackage

`default_nettype wire

### rtl/core/erpm_channels_if.sv
// valid/ready channel interfaces of the level meter
`default_nettype none

// sample beats
interface erpm_req_if import erpm_pkg::*; #(
   parameter int SAMPLE_BITS = SampleBitsDefault
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          block_end;
   logic                          clear_holds;

   modport source (output valid, sample, block_end, clear_holds, input ready);
   modport sink (input valid, sample, block_end, clear_holds, output ready);
endinterface

// level report beats
interface erpm_rsp_if import erpm_pkg::*; #(
   parameter int SAMPLE_BITS = SampleBitsDefault
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] rms_level;
   logic [SAMPLE_BITS-1:0] peak_level;
   logic [SAMPLE_BITS-1:0] rms_hold_level;
   logic [SAMPLE_BITS-1:0] peak_hold_level;

   modport source (output valid, rms_level, peak_level, rms_hold_level, peak_hold_level,
                   input ready);
   modport sink (input valid, rms_level, peak_level, rms_hold_level, peak_hold_level,
                 output ready);
endinterface

// smoothing weight register writes
interface erpm_csr_if import erpm_pkg::*;;
   logic               valid;
   logic               ready;
   logic [CsrBits-1:0] smoothing_weight;

   modport source (output valid, smoothing_weight, input ready);
   modport sink (input valid, smoothing_weight, output ready);
endinterface

`default_nettype wire

### rtl/core/erpm_serial_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module erpm_serial_mul import erpm_pkg::*; #(
   parameter int A_BITS = SampleBitsDefault,
   parameter int B_BITS = SampleBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [A_BITS-1:0]        mcand,
   input  logic [B_BITS-1:0]        mplier,
   output logic                     done,
   output logic [A_BITS+B_BITS-1:0] product
);

   localparam int CountBits = $clog2(B_BITS + 1);

   logic [A_BITS+B_BITS-1:0] prod_ff;
   logic [A_BITS+B_BITS-1:0] prod_in;
   logic [A_BITS-1:0]        mcand_ff;
   logic [CountBits-1:0]     count_ff;
   logic                     run_ff;
   logic                     done_ff;
   logic [A_BITS:0]          partial;

   // add multiplicand into the upper half when the low bit is set, then shift
   always_comb begin
      partial = {1'b0, prod_ff[A_BITS+B_BITS-1:B_BITS]}
              + (prod_ff[0] ? {1'b0, mcand_ff} : {(A_BITS + 1){1'b0}});
      prod_in = {partial, prod_ff[B_BITS-1:1]};
   end

   // step counter and completion flag
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff   <= 1'b1;
            count_ff <= CountBits'(B_BITS);
         end else if (run_ff) begin
            count_ff <= count_ff - CountBits'(1);
            if (count_ff == CountBits'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // product shift register, multiplier enters in the low half
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff  <= {{A_BITS{1'b0}}, mplier};
         mcand_ff <= mcand;
      end else if (run_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

`default_nettype wire

### rtl/core/erpm_serial_sqrt.sv
// restoring square root, one result bit (two radicand bits) per cycle
`default_nettype none

module erpm_serial_sqrt import erpm_pkg::*; #(
   parameter int ROOT_BITS = SampleBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2*ROOT_BITS-1:0] radicand,
   output logic                   done,
   output logic [ROOT_BITS-1:0]   root
);

   localparam int CountBits = $clog2(ROOT_BITS + 1);

   logic [2*ROOT_BITS-1:0] rad_ff;
   logic [ROOT_BITS+1:0]   rem_ff;
   logic [ROOT_BITS+1:0]   rem_in;
   logic [ROOT_BITS-1:0]   root_ff;
   logic [CountBits-1:0]   count_ff;
   logic                   run_ff;
   logic                   done_ff;
   logic [ROOT_BITS+3:0]   rem_shift;
   logic [ROOT_BITS+3:0]   trial;
   logic [ROOT_BITS+3:0]   rem_diff;
   logic                   fits;

   // bring down the next digit pair and try root*4+1
   always_comb begin
      rem_shift = {rem_ff, rad_ff[2*ROOT_BITS-1 -: 2]};
      trial     = {2'b00, root_ff, 2'b01};
      rem_diff  = rem_shift - trial;
      fits      = rem_shift >= trial;
      rem_in    = fits ? rem_diff[ROOT_BITS+1:0] : rem_shift[ROOT_BITS+1:0];
   end

   // step counter and completion flag
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff   <= 1'b1;
            count_ff <= CountBits'(ROOT_BITS);
         end else if (run_ff) begin
            count_ff <= count_ff - CountBits'(1);
            if (count_ff == CountBits'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // radicand, remainder and root shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         rad_ff  <= {rad_ff[2*ROOT_BITS-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= {root_ff[ROOT_BITS-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

### rtl/core/ema_rms_peak_level_meter_top.sv
// exponential rms level meter with block peak and hold maxima
//
//   channel  | dir | beat contents
//   ---------+-----+---------------------------------------------------------
//   req_bus  | in  | sample, block_end, clear_holds
//   rsp_bus  | out | rms_level, peak_level, rms_hold_level, peak_hold_level
//   csr_bus  | in  | smoothing_weight
//
// a sample passes the serial squaring multiplier and then the serial weight
// multiplier, one bit each; a block end sample also passes the serial root.
// one sample in flight at a time; req_bus is ready only when idle.
// the report sits in an output register, so a stalled rsp_bus holds the
// meter only when the next report is due. reset is synchronous, active high.
`default_nettype none

module ema_rms_peak_level_meter_top import erpm_pkg::*; #(
   parameter int SAMPLE_BITS = SampleBitsDefault,
   parameter int WEIGHT_BITS = WeightBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   erpm_req_if.sink    req_bus,
   erpm_rsp_if.source  rsp_bus,
   erpm_csr_if.sink    csr_bus
);

   localparam int MsBits   = 2 * SAMPLE_BITS - 1;
   localparam int ProdBits = MsBits + WEIGHT_BITS;

   erpm_state_type state_ff, state_in;

   logic [WEIGHT_BITS-1:0]   weight_ff;
   logic [MsBits-1:0]        mean_ff;
   logic [MsBits-1:0]        mean_in;
   logic [SAMPLE_BITS-1:0]   peak_ff;
   logic [SAMPLE_BITS-1:0]   rms_hold_ff;
   logic [SAMPLE_BITS-1:0]   peak_hold_ff;
   logic [SAMPLE_BITS-1:0]   rms_hold_in;
   logic [SAMPLE_BITS-1:0]   peak_hold_in;
   logic                     end_ff;
   logic                     down_ff;

   logic                     rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]   rsp_rms_ff;
   logic [SAMPLE_BITS-1:0]   rsp_peak_ff;
   logic [SAMPLE_BITS-1:0]   rsp_rms_hold_ff;
   logic [SAMPLE_BITS-1:0]   rsp_peak_hold_ff;

   logic [SAMPLE_BITS-1:0]   sample_mag;
   logic [2*SAMPLE_BITS-1:0] sq_prod;
   logic [MsBits-1:0]        square;
   logic                     sq_above;
   logic [MsBits-1:0]        diff;
   logic [ProdBits-1:0]      sc_prod;
   logic [MsBits-1:0]        scaled;
   logic                     inexact;
   logic [SAMPLE_BITS-1:0]   rms_root;

   logic req_ready;
   logic accept;
   logic sq_done;
   logic sc_start;
   logic sc_done;
   logic mean_load;
   logic rt_start;
   logic rt_done;
   logic emit;
   logic rsp_free;

   // magnitude of the sample; the most negative code wraps to its exact value
   assign sample_mag = req_bus.sample[SAMPLE_BITS-1]
                     ? ($unsigned(~req_bus.sample) + SAMPLE_BITS'(1))
                     : $unsigned(req_bus.sample);

   assign accept   = req_ready && req_bus.valid;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // squaring unit
   erpm_serial_mul #(
      .A_BITS (SAMPLE_BITS),
      .B_BITS (SAMPLE_BITS)
   ) u_square (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .mcand   (sample_mag),
      .mplier  (sample_mag),
      .done    (sq_done),
      .product (sq_prod)
   );

   // distance between the new square and the mean
   always_comb begin
      square   = sq_prod[MsBits-1:0];
      sq_above = square >= mean_ff;
      diff     = sq_above ? (square - mean_ff) : (mean_ff - square);
   end

   // weight scaling unit
   erpm_serial_mul #(
      .A_BITS (MsBits),
      .B_BITS (WEIGHT_BITS)
   ) u_scale (
      .clock   (clock),
      .reset   (reset),
      .start   (sc_start),
      .mcand   (diff),
      .mplier  (weight_ff),
      .done    (sc_done),
      .product (sc_prod)
   );

   // floored move of the mean; a dropped fraction rounds a fall down by one
   always_comb begin
      scaled  = sc_prod[ProdBits-1:WEIGHT_BITS];
      inexact = |sc_prod[WEIGHT_BITS-1:0];
      mean_in = down_ff ? (mean_ff - scaled - MsBits'(inexact)) : (mean_ff + scaled);
   end

   // root unit
   erpm_serial_sqrt #(
      .ROOT_BITS (SAMPLE_BITS)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start),
      .radicand ({1'b0, mean_in}),
      .done     (rt_done),
      .root     (rms_root)
   );

   // hold maxima raised to this block's levels
   always_comb begin
      rms_hold_in  = (rms_root > rms_hold_ff) ? rms_root : rms_hold_ff;
      peak_hold_in = (peak_ff > peak_hold_ff) ? peak_ff : peak_hold_ff;
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer next state and controls
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      sc_start  = 1'b0;
      mean_load = 1'b0;
      rt_start  = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (sq_done) begin
               sc_start = 1'b1;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (sc_done) begin
               mean_load = 1'b1;
               if (end_ff) begin
                  rt_start = 1'b1;
                  state_in = ST_ROOT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ROOT: begin
            if (rt_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // meter state
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= WeightResetValue[WEIGHT_BITS-1:0];
         mean_ff      <= '0;
         peak_ff      <= '0;
         rms_hold_ff  <= '0;
         peak_hold_ff <= '0;
      end else begin
         if (csr_bus.valid) begin
            weight_ff <= csr_bus.smoothing_weight[WEIGHT_BITS-1:0];
         end
         if (accept) begin
            if (req_bus.clear_holds) begin
               rms_hold_ff  <= '0;
               peak_hold_ff <= '0;
            end
            if (sample_mag > peak_ff) begin
               peak_ff <= sample_mag;
            end
         end
         if (mean_load) begin
            mean_ff <= mean_in;
         end
         if (emit) begin
            rms_hold_ff  <= rms_hold_in;
            peak_hold_ff <= peak_hold_in;
            peak_ff      <= '0;
         end
      end
   end

   // per-sample flags
   always_ff @(posedge clock) begin
      if (accept) begin
         end_ff <= req_bus.block_end;
      end
      if (sc_start) begin
         down_ff <= !sq_above;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_rms_ff       <= rms_root;
         rsp_peak_ff      <= peak_ff;
         rsp_rms_hold_ff  <= rms_hold_in;
         rsp_peak_hold_ff <= peak_hold_in;
      end
   end

   assign req_bus.ready           = req_ready;
   assign csr_bus.ready           = 1'b1;
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.rms_level       = rsp_rms_ff;
   assign rsp_bus.peak_level      = rsp_peak_ff;
   assign rsp_bus.rms_hold_level  = rsp_rms_hold_ff;
   assign rsp_bus.peak_hold_level = rsp_peak_hold_ff;

endmodule

`default_nettype wire

### rtl/core/erpm_checker.sv
// port checks of the level meter, bound to the top level
`default_nettype none

`include "ema_rms_peak_level_meter_top_assert.svh"

module erpm_checker import erpm_pkg::*; #(
   parameter int SAMPLE_BITS = SampleBitsDefault
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rms_level,
   input logic [SAMPLE_BITS-1:0] peak_level,
   input logic [SAMPLE_BITS-1:0] rms_hold_level,
   input logic [SAMPLE_BITS-1:0] peak_hold_level
);

   // one sample in flight: no second beat right after a taken one
   `ERPM_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // holds never below the levels they report with
   `ERPM_ASSERT_IMPLY(a_rms_hold_covers, clock, reset, rsp_valid, rms_hold_level >= rms_level)
   `ERPM_ASSERT_IMPLY(a_peak_hold_covers, clock, reset, rsp_valid,
                      peak_hold_level >= peak_level)

   // a stalled report stays put
   `ERPM_ASSERT_NEXT(a_report_held, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rms_level) && $stable(peak_level)
                     && $stable(rms_hold_level) && $stable(peak_hold_level))

endmodule

bind ema_rms_peak_level_meter_top erpm_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rms_level       (rsp_bus.rms_level),
   .peak_level      (rsp_bus.peak_level),
   .rms_hold_level  (rsp_bus.rms_hold_level),
   .peak_hold_level (rsp_bus.peak_hold_level)
);

`default_nettype wire
